### sv/julia_set_point_test_core_assert.svh
// assertion macros for the julia set point test core
`ifndef JULIA_SET_POINT_TEST_CORE_ASSERT_SVH
`define JULIA_SET_POINT_TEST_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define JSPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("julia point test core check failed");

// next-cycle implication, disabled while in reset
`define JSPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("julia point test core check failed");

`endif

### sv/jset_pkg.sv
// shared constants and helpers for the julia set point test core
package jset_pkg;

  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int DATA_W     = 32;
  localparam int STEP_W     = 31;
  localparam int LIMIT_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_BITS  = 28;
  localparam int SAT_W      = 43;

  localparam int COLUMN_COUNT_DEF = 1024;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C_REAL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_C_IMAG    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIM  = 3'd4;

  // reset values
  localparam logic signed [DATA_W-1:0] X_MIN_RST    = -32'sd536870912;
  localparam logic [STEP_W-1:0]        X_STEP_RST   = 31'd1048576;
  localparam logic signed [DATA_W-1:0] C_REAL_RST   = -32'sd201594470;
  localparam logic signed [DATA_W-1:0] C_IMAG_RST   = 32'sd5972689;
  localparam logic [LIMIT_W-1:0]       ITER_LIM_RST = 16'd1000;

  // radius two squared, 4.0 in Q8.56
  localparam logic [63:0] ESCAPE_MAG = 64'h0400_0000_0000_0000;

  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(64'sh0000_0000_7fff_ffff);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-64'sh0000_0000_8000_0000);

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fff_ffff;
    end else if (v < SAT_MIN) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

### sv/julia_set_point_test_core.sv
// Julia set escape-time test for one grid point: start launches a point when busy is low.
// The column is first wrapped into the grid by repeated subtraction, the real coordinate
// is then formed by a multiply and then an add and clamp, and every orbit step then has a
// multiply state and an update state: three 32x32 products are registered, then the
// escape compare and the clamped square-plus-c update are made from them. An escaping
// point stops at its first failed check. The result appears on out_valid for exactly one
// cycle and cannot be held off, so the receiver must take every beat when it is shown;
// busy is already low in that cycle.
`include "julia_set_point_test_core_assert.svh"

module julia_set_point_test_core import jset_pkg::*; #(
  parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [COL_W-1:0]         in_column,
  input  logic signed [DATA_W-1:0] in_point_imag,
  input  logic [ROW_W-1:0]         in_row_tag,
  output logic                     out_valid,
  output logic                     out_in_set,
  output logic [COL_W-1:0]         out_column_out,
  output logic [ROW_W-1:0]         out_row_out,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  localparam int CNT_BITS = $clog2(COLUMN_COUNT + 1);
  localparam int CMP_W    = (COL_W > CNT_BITS) ? COL_W : CNT_BITS;
  localparam logic [CMP_W-1:0] COL_LIMIT = CMP_W'(COLUMN_COUNT);
  localparam int XPROD_W  = COL_W + STEP_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WRAP = 3'd1;
  localparam logic [2:0] ST_XMUL = 3'd2;
  localparam logic [2:0] ST_XADD = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;

  // configuration registers
  logic signed [DATA_W-1:0] x_min_r;
  logic [STEP_W-1:0]        x_step_r;
  logic signed [DATA_W-1:0] c_real_r;
  logic signed [DATA_W-1:0] c_imag_r;
  logic [LIMIT_W-1:0]       iter_lim_r;

  logic [2:0]               state_r, state_nxt;
  logic [COL_W-1:0]         col_r;
  logic [ROW_W-1:0]         row_r;
  logic signed [DATA_W-1:0] re_r, im_r;
  logic [XPROD_W-1:0]       xprod_r;
  logic signed [63:0]       aa_r, bb_r, ab_r;
  logic [LIMIT_W-1:0]       iter_r;
  logic                     first_r;
  logic                     out_valid_r, out_in_set_r;
  logic [COL_W-1:0]         out_col_r;
  logic [ROW_W-1:0]         out_row_r;

  logic                     accept;
  logic [CMP_W-1:0]         col_ext;
  logic                     col_wrap;
  logic signed [SAT_W-1:0]  x_sum;
  logic signed [63:0]       diff;
  logic signed [SAT_W-1:0]  re_sum, im_sum;
  logic signed [DATA_W-1:0] re_nxt, im_nxt;
  logic [63:0]              mag;
  logic                     escape;
  logic                     last_step;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign col_ext  = CMP_W'(col_r);
  assign col_wrap = (col_ext >= COL_LIMIT);

  assign x_sum = SAT_W'(x_min_r) + $signed({{(SAT_W-XPROD_W){1'b0}}, xprod_r});

  // square plus c, floor shifts then clamp
  assign diff   = aa_r - bb_r;
  assign re_sum = $signed({{(SAT_W-64+FRAC_BITS){diff[63]}}, diff[63:FRAC_BITS]})
                + SAT_W'(c_real_r);
  assign im_sum = $signed({{(SAT_W-65+FRAC_BITS){ab_r[63]}}, ab_r[63:FRAC_BITS-1]})
                + SAT_W'(c_imag_r);
  assign re_nxt = sat32(re_sum);
  assign im_nxt = sat32(im_sum);

  assign mag       = 64'(aa_r) + 64'(bb_r);
  assign escape    = (mag > ESCAPE_MAG);
  assign last_step = (iter_r == iter_lim_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        if (!col_wrap) state_nxt = ST_XMUL;
      end
      ST_XMUL: state_nxt = ST_XADD;
      ST_XADD: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_UPD;
      ST_UPD: begin
        if (first_r) begin
          state_nxt = ST_MUL;
        end else if (escape || last_step) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      x_min_r     <= X_MIN_RST;
      x_step_r    <= X_STEP_RST;
      c_real_r    <= C_REAL_RST;
      c_imag_r    <= C_IMAG_RST;
      iter_lim_r  <= ITER_LIM_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_UPD) && !first_r && (escape || last_step);
      if (cfg_we) begin
        case (cfg_index)
          REG_X_MIN:    x_min_r    <= cfg_data;
          REG_X_STEP:   x_step_r   <= cfg_data[STEP_W-1:0];
          REG_C_REAL:   c_real_r   <= cfg_data;
          REG_C_IMAG:   c_imag_r   <= cfg_data;
          REG_ITER_LIM: iter_lim_r <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          col_r <= in_column;
          row_r <= in_row_tag;
          im_r  <= in_point_imag;
        end
      end
      ST_WRAP: begin
        if (col_wrap) col_r <= COL_W'(col_ext - COL_LIMIT);
      end
      ST_XMUL: xprod_r <= XPROD_W'(col_r) * XPROD_W'(x_step_r);
      ST_XADD: begin
        re_r    <= sat32(x_sum);
        first_r <= 1'b1;
        iter_r  <= '0;
      end
      ST_MUL: begin
        aa_r <= 64'(re_r) * 64'(re_r);
        bb_r <= 64'(im_r) * 64'(im_r);
        ab_r <= 64'(re_r) * 64'(im_r);
      end
      ST_UPD: begin
        re_r    <= re_nxt;
        im_r    <= im_nxt;
        first_r <= 1'b0;
        if (!first_r && !escape && !last_step) iter_r <= iter_r + 1'b1;
        if (!first_r && (escape || last_step)) begin
          out_in_set_r <= !escape;
          out_col_r    <= col_r;
          out_row_r    <= row_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_in_set     = out_in_set_r;
  assign out_column_out = out_col_r;
  assign out_row_out    = out_row_r;

  `JSPT_ASSERT_NOW(a_result_when_idle, clk, rst_n, out_valid, !busy)
  `JSPT_ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy)
  `JSPT_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  `JSPT_ASSERT_NOW(a_upd_after_mul, clk, rst_n, state_r == ST_UPD, $past(state_r) == ST_MUL)

endmodule

### tb/tb.sv
// testbench for the julia set point test core, checking each point against an escape-time predictor
`timescale 1ns / 100ps

module tb;
  import jset_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam logic [DATA_W-1:0] Q_TWO     = 32'h2000_0000;
  localparam logic [DATA_W-1:0] Q_NEG_TWO = 32'hE000_0000;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef struct packed {
    logic             in_set;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
  } point_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [COL_W-1:0]         in_column;
  logic signed [DATA_W-1:0] in_point_imag;
  logic [ROW_W-1:0]         in_row_tag;
  logic                     out_valid;
  logic                     out_in_set;
  logic [COL_W-1:0]         out_column_out;
  logic [ROW_W-1:0]         out_row_out;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DATA_W-1:0]        cfg_data;

  // local copy of the register file
  logic signed [DATA_W-1:0] x_min_r    = X_MIN_RST;
  logic [STEP_W-1:0]        x_step_r   = X_STEP_RST;
  logic signed [DATA_W-1:0] c_real_r   = C_REAL_RST;
  logic signed [DATA_W-1:0] c_imag_r   = C_IMAG_RST;
  logic [LIMIT_W-1:0]       iter_lim_r = ITER_LIM_RST;

  point_result_t pending_points[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  bit            no_idle = 1'b0;

  julia_set_point_test_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_column      (in_column),
    .in_point_imag  (in_point_imag),
    .in_row_tag     (in_row_tag),
    .out_valid      (out_valid),
    .out_in_set     (out_in_set),
    .out_column_out (out_column_out),
    .out_row_out    (out_row_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic longint clamp32(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // F <- F^2 + c with floor shifts, each part clamped to Q4.28
  function automatic void square_plus_c(inout longint re, inout longint im);
    longint nr, ni;
    nr = ((re * re - im * im) >>> FRAC_BITS) + longint'(c_real_r);
    ni = ((re * im) >>> (FRAC_BITS - 1)) + longint'(c_imag_r);
    re = clamp32(nr);
    im = clamp32(ni);
  endfunction

  function automatic logic predict_in_set(logic [COL_W-1:0] col,
                                          logic signed [DATA_W-1:0] imag);
    longint          re, im;
    longint unsigned mag;
    int              k;
    re = clamp32(longint'(x_min_r) + longint'(col) * longint'(x_step_r));
    im = longint'(imag);
    square_plus_c(re, im);
    for (k = 0; k <= int'(iter_lim_r); k++) begin
      mag = re * re;
      mag = mag + im * im;
      if (mag > ESCAPE_MAG) return 1'b0;
      square_plus_c(re, im);
    end
    return 1'b1;
  endfunction

  // all five registers in consecutive cycles, block idle
  task automatic write_settings(input logic [DATA_W-1:0] xmin, input logic [DATA_W-1:0] xstep,
                                input logic [DATA_W-1:0] cre, input logic [DATA_W-1:0] cim,
                                input logic [DATA_W-1:0] lim);
    cfg_we <= 1'b1;
    cfg_index <= REG_X_MIN;
    cfg_data <= xmin;
    @(posedge clk);
    cfg_index <= REG_X_STEP;
    cfg_data <= xstep;
    @(posedge clk);
    cfg_index <= REG_C_REAL;
    cfg_data <= cre;
    @(posedge clk);
    cfg_index <= REG_C_IMAG;
    cfg_data <= cim;
    @(posedge clk);
    cfg_index <= REG_ITER_LIM;
    cfg_data <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    x_min_r = xmin;
    x_step_r = xstep[STEP_W-1:0];
    c_real_r = cre;
    c_imag_r = cim;
    iter_lim_r = lim[LIMIT_W-1:0];
  endtask

  task automatic launch_point(input logic [COL_W-1:0] col, input logic signed [DATA_W-1:0] imag,
                              input logic [ROW_W-1:0] row);
    int            gap;
    point_result_t want;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_column <= col;
    in_point_imag <= imag;
    in_row_tag <= row;
    @(posedge clk);
    while (busy) @(posedge clk);
    want.in_set = predict_in_set(col, imag);
    want.column = col;
    want.row = row;
    pending_points.push_back(want);
  endtask

  task automatic drain_points();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic test_reset_settings();
    launch_point(10'd0, 32'sd0, 10'd0);
    launch_point(10'd512, 32'sd0, 10'd1023);
    launch_point(10'd1023, 32'sh7FFF_FFFF, 10'd5);
    launch_point(10'd256, 32'shFC00_0000, 10'd700);
  endtask

  task automatic test_coordinate_extremes();
    drain_points();
    // x clamps high, top bit of the step write is dropped
    write_settings(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'd20);
    launch_point(10'd1023, 32'sd0, 10'd1);
    launch_point(10'd0, 32'sh8000_0000, 10'd2);
    drain_points();
    write_settings(32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd20);
    launch_point(10'd1023, 32'sh7FFF_FFFF, 10'd3);
    launch_point(10'd0, 32'sd0, 10'd1023);
    drain_points();
    // orbit pinned at 2.0 for columns 0 and 1, magnitude exactly on the radius, never escapes; column 2 escapes
    write_settings(32'h0, Q_TWO, Q_NEG_TWO, 32'h0, 32'd20);
    launch_point(10'd0, 32'sd0, 10'd4);
    launch_point(10'd1, 32'sd0, 10'd5);
    launch_point(10'd2, 32'sd0, 10'd6);
  endtask

  task automatic test_iteration_limits();
    drain_points();
    // limit zero: only the first check, so c = 2.0 still counts as inside
    write_settings(32'h0, 32'h0, Q_TWO, 32'h0, 32'h0);
    launch_point(10'd0, 32'sd0, 10'd7);
    drain_points();
    write_settings(32'h0, 32'h0, Q_TWO, 32'h0, 32'hABCD_0001);
    launch_point(10'd0, 32'sd0, 10'd8);
    drain_points();
    write_settings(32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF);
    launch_point(10'd0, 32'sd0, 10'd9);
    // clamped orbit escapes at the next check
    launch_point(10'd0, 32'sh7FFF_FFFF, 10'd10);
    drain_points();
    write_settings(32'h0, 32'h0, Q_NEG_TWO, 32'h0, 32'hFFFF_FFFF);
    launch_point(10'd0, 32'sd0, 10'd11);
  endtask

  task automatic test_random_orbits();
    logic [DATA_W-1:0]        xmin, xstep, cre, cim;
    logic [COL_W-1:0]         col;
    logic [ROW_W-1:0]         row;
    logic signed [DATA_W-1:0] imag;
    int                       lim, phase, n;
    for (phase = 0; phase < 6; phase++) begin
      drain_points();
      if (phase == 5) begin
        xmin = $urandom;
        xstep = $urandom;
        cre = $urandom;
        cim = $urandom;
      end else begin
        // grid starts between -2 and -1.5 and spans about 2 to 8 across, c in the interesting region
        xmin = 32'hE000_0000 + $urandom_range(0, 32'h0800_0000);
        xstep = $urandom_range(32'h0008_0000, 32'h0020_0000);
        cre = $urandom_range(0, 32'h1C00_0000) - 32'h1000_0000;
        cim = $urandom_range(0, 32'h1400_0000) - 32'h0A00_0000;
      end
      lim = (phase == 0) ? 1 : $urandom_range(0, 48);
      no_idle = (phase == 2);
      write_settings(xmin, xstep, cre, cim, 32'(lim));
      for (n = 0; n < 96; n++) begin
        if ($urandom_range(0, 31) == 0) drain_points();
        col = COL_W'($urandom_range(0, 1023));
        row = ROW_W'($urandom_range(0, 1023));
        if ($urandom_range(0, 7) == 0) begin
          imag = $urandom;
        end else begin
          imag = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
        end
        launch_point(col, imag, row);
      end
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    point_result_t want;
    if (rst_n && out_valid) begin
      if (pending_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected beat: in_set=%0b col=%0d row=%0d",
                   out_in_set, out_column_out, out_row_out);
        end
      end else begin
        want = pending_points.pop_front();
        if (out_in_set !== want.in_set || out_column_out !== want.column ||
            out_row_out !== want.row) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected in_set=%0b col=%0d row=%0d, got in_set=%0b col=%0d row=%0d",
                     want.in_set, want.column, want.row,
                     out_in_set, out_column_out, out_row_out);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_column <= '0;
    in_point_imag <= '0;
    in_row_tag <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_X_MIN;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_settings();
    test_coordinate_extremes();
    test_iteration_limits();
    test_random_orbits();
    drain_points();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
